// ===== rtl/cst_pkg.sv =====
`timescale 1ns / 1ps

package cst_pkg;

  // default table depth
  localparam int SLOTS_DEF = 256;

  // field widths
  localparam int IDX_W  = 8;
  localparam int MODE_W = 2;
  localparam int PRIO_W = 8;
  localparam int CNT_W  = 9;

  // stream word widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // free search works on groups of slots
  localparam int GRP_BW = 4;
  localparam int GRP_W  = 1 << GRP_BW;

  // delivery modes that carry meaning on query
  localparam logic [MODE_W-1:0] MODE_RELIABLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ORDERED  = 2'd2;

  typedef enum logic [1:0] {
    OP_REGISTER,
    OP_OPEN,
    OP_UNREGISTER,
    OP_QUERY
  } cst_op_t;

  typedef enum logic [1:0] {
    STS_OK,
    STS_IN_USE,
    STS_NOT_FOUND,
    STS_FULL
  } cst_status_t;

  typedef enum logic {
    S_IDLE,
    S_DONE
  } cst_state_t;

  // one stored slot entry
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PRIO_W-1:0] prio;
  } cst_entry_t;

  // result of the free slot search
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] slot;
  } cst_pick_t;

  // input word layout, lowest field last
  typedef struct packed {
    logic [5:0]        pad;
    logic [PRIO_W-1:0] priority_in;
    logic [MODE_W-1:0] mode_in;
    logic [IDX_W-1:0]  slot_index;
  } cst_in_t;

  // output word layout, lowest field last
  typedef struct packed {
    logic [1:0]        pad;
    logic [CNT_W-1:0]  used_count;
    logic [PRIO_W-1:0] priority_out;
    logic              is_ordered_out;
    logic              is_reliable_out;
    logic              is_valid;
    logic [IDX_W-1:0]  slot_out;
    cst_status_t       status;
  } cst_out_t;

endpackage

// ===== rtl/cst_slot_mem.sv =====
`timescale 1ns / 1ps

module cst_slot_mem import cst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output cst_entry_t    rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  cst_entry_t    wr_data
);

  cst_entry_t store_mem [SLOTS];
  cst_entry_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/cst_free_search.sv =====
`timescale 1ns / 1ps

module cst_free_search import cst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk,
  input  logic             capture,
  input  logic [IDX_W-1:0] hint,
  input  logic [SLOTS-1:0] valid,
  output cst_pick_t        pick
);

  localparam int IW    = $clog2(SLOTS);
  localparam int NG    = (SLOTS + GRP_W - 1) / GRP_W;
  localparam int PADW  = NG * GRP_W;
  localparam int GIW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int PW    = GIW + GRP_BW;
  localparam int HINTS = 1 << IDX_W;

  logic [IW-1:0]   start_lut [HINTS];
  logic [IW-1:0]   start;
  logic [PADW-1:0] free_pad;
  logic [PADW-1:0] ge_at;
  logic [NG-1:0]   hi_grp_nxt;
  logic [NG-1:0]   any_grp_nxt;

  logic [IW-1:0]   start_r;
  logic [NG-1:0]   hi_grp_r;
  logic [NG-1:0]   any_grp_r;

  logic              use_hi;
  logic [NG-1:0]     grp_vec;
  logic [GIW-1:0]    grp_sel;
  logic [GRP_W-1:0]  grp_bits;
  logic [GRP_W-1:0]  grp_mask;
  logic [GRP_W-1:0]  cand;
  logic [GRP_BW-1:0] bit_sel;

  // hint wrapped into the table
  for (genvar i = 0; i < HINTS; i++) begin : g_lut
    assign start_lut[i] = IW'(i % SLOTS);
  end
  assign start = start_lut[hint];

  // free map, padding slots count as taken
  for (genvar i = 0; i < PADW; i++) begin : g_free
    if (i < SLOTS) begin : g_real
      assign free_pad[i] = ~valid[i];
    end else begin : g_pad
      assign free_pad[i] = 1'b0;
    end
  end

  // per-group flags: any free at or above start, any free at all
  always_comb begin
    for (int i = 0; i < PADW; i++) begin
      ge_at[i] = (i >= int'(start));
    end
    for (int g = 0; g < NG; g++) begin
      hi_grp_nxt[g]  = |(free_pad[g*GRP_W +: GRP_W] & ge_at[g*GRP_W +: GRP_W]);
      any_grp_nxt[g] = |free_pad[g*GRP_W +: GRP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      start_r   <= start;
      hi_grp_r  <= hi_grp_nxt;
      any_grp_r <= any_grp_nxt;
    end
  end

  // second level: pick group, then bit within it
  always_comb begin
    use_hi  = |hi_grp_r;
    grp_vec = use_hi ? hi_grp_r : any_grp_r;
    grp_sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_vec[g]) grp_sel = GIW'(g);
    end
    grp_bits = '0;
    for (int g = 0; g < NG; g++) begin
      if (GIW'(g) == grp_sel) grp_bits = free_pad[g*GRP_W +: GRP_W];
    end
    for (int b = 0; b < GRP_W; b++) begin
      grp_mask[b] = ({grp_sel, GRP_BW'(b)} >= PW'(start_r));
    end
    cand    = grp_bits & (use_hi ? grp_mask : '1);
    bit_sel = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (cand[b]) bit_sel = GRP_BW'(b);
    end
    pick.found = |any_grp_r;
    pick.slot  = IDX_W'({grp_sel, bit_sel});
  end

endmodule

// ===== rtl/channel_slot_table.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake                Word contents
// in_      in   in_tvalid / in_tready    tuser: opcode; tdata: slot_index, mode_in, priority_in
// out_     out  out_tvalid / out_tready  tdata: status .. used_count, one word per input word
//
// Every word goes through two steps: accept (memory read, search flags registered), then finish.
// The finish step holds while the output register is still full and out_tready is low.
// The next word is taken as soon as the block is back in idle, even if a result waits.
// Reset clears all valid bits and the used count at once; entry memory needs no clearing.

module channel_slot_table import cst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // slot_index, mode_in, priority_in
  input  logic [1:0]             in_tuser,   // opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status, slot_out, is_valid, is_reliable_out,
                                             // is_ordered_out, priority_out, used_count
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  cst_in_t  in_word;
  logic     in_fire;
  logic     in_range;

  cst_state_t state_r, state_nxt;
  cst_op_t    op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [MODE_W-1:0] mode_r;
  logic [PRIO_W-1:0] prio_r;
  logic              in_range_r;

  logic [SLOTS-1:0] valid_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_tvalid_r;
  cst_out_t         out_data_r;

  cst_entry_t rd_data;
  cst_entry_t wr_data;
  cst_pick_t  pick;

  logic          load_en;
  logic          vbit;
  logic          set_en, clr_en;
  logic [IW-1:0] tgt;
  cst_out_t      res;

  assign in_word   = cst_in_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_range  = int'(in_word.slot_index) < SLOTS;

  // entry memory: read on accept, write on finish, never in the same cycle
  cst_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .rd_en   (in_fire && in_range),
    .rd_addr (in_word.slot_index[IW-1:0]),
    .rd_data (rd_data),
    .wr_en   (load_en && set_en),
    .wr_addr (tgt),
    .wr_data (wr_data)
  );

  // rotating free slot search
  cst_free_search #(.SLOTS(SLOTS)) u_search (
    .clk     (clk),
    .capture (in_fire),
    .hint    (in_word.slot_index),
    .valid   (valid_r),
    .pick    (pick)
  );

  // operand capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= cst_op_t'(in_tuser);
      idx_r      <= in_word.slot_index;
      mode_r     <= in_word.mode_in;
      prio_r     <= in_word.priority_in;
      in_range_r <= in_range;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    load_en   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DONE;
      end
      S_DONE: begin
        load_en = !out_tvalid_r || out_tready;
        if (load_en) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // finish: decide status, update table
  assign vbit         = in_range_r && valid_r[idx_r[IW-1:0]];
  assign wr_data.mode = mode_r;
  assign wr_data.prio = prio_r;

  always_comb begin
    res            = '0;
    res.status     = STS_OK;
    res.slot_out   = idx_r;
    set_en         = 1'b0;
    clr_en         = 1'b0;
    tgt            = idx_r[IW-1:0];
    case (op_r)
      OP_REGISTER: begin
        if (!in_range_r) begin
          res.status = STS_NOT_FOUND;
        end else if (vbit) begin
          res.status = STS_IN_USE;
        end else begin
          set_en = 1'b1;
        end
      end
      OP_OPEN: begin
        if (pick.found) begin
          set_en       = 1'b1;
          tgt          = pick.slot[IW-1:0];
          res.slot_out = pick.slot;
        end else begin
          res.status   = STS_FULL;
          res.slot_out = '0;
        end
      end
      OP_UNREGISTER: begin
        if (!vbit) begin
          res.status = STS_NOT_FOUND;
        end else begin
          clr_en = 1'b1;
        end
      end
      default: begin
        if (!in_range_r) begin
          res.status = STS_NOT_FOUND;
        end else if (vbit) begin
          res.is_valid        = 1'b1;
          res.is_reliable_out = (rd_data.mode == MODE_RELIABLE) ||
                                (rd_data.mode == MODE_ORDERED);
          res.is_ordered_out  = (rd_data.mode == MODE_ORDERED);
          res.priority_out    = rd_data.prio;
        end
      end
    endcase
    count_nxt = count_r;
    if (set_en) count_nxt = count_r + 1'b1;
    if (clr_en) count_nxt = count_r - 1'b1;
    res.used_count = CNT_W'(count_nxt);
  end

  // valid bits and used count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (load_en) begin
      if (set_en) valid_r[tgt] <= 1'b1;
      if (clr_en) valid_r[tgt] <= 1'b0;
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_en) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) out_data_r <= res;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  // checks
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == count_r)
    else $error("used count differs from number of valid slots");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("used count above table size");

  a_pick_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_en && op_r == OP_OPEN && pick.found |-> !valid_r[pick.slot[IW-1:0]])
    else $error("open picked a slot already in use");

  a_claim_counts: assert property (@(posedge clk) disable iff (!rst_n)
    load_en && set_en |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("claim did not advance used count");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cst_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 20;
  localparam int TOTAL_WORDS  = 1150;
  localparam int IDLE_PCT     = 37;

  // one directed stimulus row, with typed-in result where given
  typedef struct {
    cst_op_t          op;
    logic [IDX_W-1:0] idx;
    logic [1:0]       mode;
    logic [7:0]       prio;
    bit               typed;
    cst_status_t      st;
    logic [IDX_W-1:0] slot;
    logic             v;
    logic             r;
    logic             o;
    logic [7:0]       p;
    logic [CNT_W-1:0] cnt;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;  // slot_index, mode_in, priority_in
  logic [1:0]             in_tuser = '0;  // opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // status, slot_out, is_valid, is_reliable_out,
                                          // is_ordered_out, priority_out, used_count

  // predicted table contents
  bit               slot_used [SLOTS_DEF];
  bit               ever_used [SLOTS_DEF];
  logic [1:0]       slot_mode [SLOTS_DEF];
  logic [7:0]       slot_prio [SLOTS_DEF];
  int unsigned      used_cnt = 0;

  cst_out_t         results_due [$];
  int unsigned      n_sent = 0;
  int unsigned      err_cnt = 0;
  int unsigned      idle_cycles = 0;
  bit               hold_done = 1'b0;
  bit               tx_steady;
  bit               rx_steady;

  // steady window: neither side idles
  assign tx_steady = (n_sent >= 650) && (n_sent < 800);
  assign rx_steady = (n_sent >= 640) && (n_sent < 810);

  dir_row_t dir_tab [0:19] = '{
    '{OP_UNREGISTER, 8'd5,   2'd0, 8'h00, 1'b1, STS_NOT_FOUND, 8'd5,   1'b0, 1'b0, 1'b0, 8'h00, 9'd0},
    '{OP_REGISTER,   8'd0,   2'd0, 8'h00, 1'b1, STS_OK,        8'd0,   1'b0, 1'b0, 1'b0, 8'h00, 9'd1},
    '{OP_REGISTER,   8'd255, 2'd2, 8'hFF, 1'b1, STS_OK,        8'd255, 1'b0, 1'b0, 1'b0, 8'h00, 9'd2},
    '{OP_REGISTER,   8'd255, 2'd1, 8'h01, 1'b1, STS_IN_USE,    8'd255, 1'b0, 1'b0, 1'b0, 8'h00, 9'd2},
    '{OP_QUERY,      8'd255, 2'd0, 8'h00, 1'b1, STS_OK,        8'd255, 1'b1, 1'b1, 1'b1, 8'hFF, 9'd2},
    '{OP_QUERY,      8'd0,   2'd3, 8'hFF, 1'b1, STS_OK,        8'd0,   1'b1, 1'b0, 1'b0, 8'h00, 9'd2},
    '{OP_OPEN,       8'd255, 2'd1, 8'h5A, 1'b1, STS_OK,        8'd1,   1'b0, 1'b0, 1'b0, 8'h00, 9'd3},
    '{OP_QUERY,      8'd1,   2'd0, 8'h00, 1'b1, STS_OK,        8'd1,   1'b1, 1'b1, 1'b0, 8'h5A, 9'd3},
    '{OP_REGISTER,   8'd128, 2'd3, 8'hA5, 1'b1, STS_OK,        8'd128, 1'b0, 1'b0, 1'b0, 8'h00, 9'd4},
    '{OP_QUERY,      8'd128, 2'd0, 8'h00, 1'b1, STS_OK,        8'd128, 1'b1, 1'b0, 1'b0, 8'hA5, 9'd4},
    '{OP_UNREGISTER, 8'd128, 2'd0, 8'h00, 1'b1, STS_OK,        8'd128, 1'b0, 1'b0, 1'b0, 8'h00, 9'd3},
    '{OP_QUERY,      8'd128, 2'd0, 8'h00, 1'b1, STS_OK,        8'd128, 1'b0, 1'b0, 1'b0, 8'h00, 9'd3},
    '{OP_UNREGISTER, 8'd128, 2'd0, 8'h00, 1'b1, STS_NOT_FOUND, 8'd128, 1'b0, 1'b0, 1'b0, 8'h00, 9'd3},
    '{OP_OPEN,       8'd0,   2'd2, 8'h80, 1'b0, STS_OK,        8'd0,   1'b0, 1'b0, 1'b0, 8'h00, 9'd0},
    '{OP_OPEN,       8'd254, 2'd0, 8'h7F, 1'b0, STS_OK,        8'd0,   1'b0, 1'b0, 1'b0, 8'h00, 9'd0},
    '{OP_REGISTER,   8'd170, 2'd1, 8'h55, 1'b0, STS_OK,        8'd0,   1'b0, 1'b0, 1'b0, 8'h00, 9'd0},
    '{OP_REGISTER,   8'd85,  2'd2, 8'hAA, 1'b0, STS_OK,        8'd0,   1'b0, 1'b0, 1'b0, 8'h00, 9'd0},
    '{OP_QUERY,      8'd85,  2'd0, 8'h00, 1'b0, STS_OK,        8'd0,   1'b0, 1'b0, 1'b0, 8'h00, 9'd0},
    '{OP_QUERY,      8'd170, 2'd3, 8'h00, 1'b0, STS_OK,        8'd0,   1'b0, 1'b0, 1'b0, 8'h00, 9'd0},
    '{OP_UNREGISTER, 8'd0,   2'd0, 8'h00, 1'b0, STS_OK,        8'd0,   1'b0, 1'b0, 1'b0, 8'h00, 9'd0}
  };

  channel_slot_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // claim a slot in the predicted table
  function automatic void take_slot(logic [IDX_W-1:0] s, logic [1:0] mode, logic [7:0] prio);
    slot_used[s] = 1'b1;
    ever_used[s] = 1'b1;
    slot_mode[s] = mode;
    slot_prio[s] = prio;
    used_cnt++;
  endfunction

  // apply one table operation, return the result word it produces
  function automatic cst_out_t apply_slot_op(cst_op_t op, logic [IDX_W-1:0] idx,
                                             logic [1:0] mode, logic [7:0] prio);
    cst_out_t         r;
    logic [IDX_W-1:0] s;
    bit               found;
    int               k;
    r = '0;
    r.status = STS_OK;
    r.slot_out = idx;
    found = 1'b0;
    case (op)
      OP_REGISTER: begin
        if (slot_used[idx]) r.status = STS_IN_USE;
        else take_slot(idx, mode, prio);
      end
      OP_OPEN: begin
        // rotating search upward from the hint
        for (k = 0; k < SLOTS_DEF; k++) begin
          s = idx + IDX_W'(k);
          if (!found && !slot_used[s]) begin
            found = 1'b1;
            take_slot(s, mode, prio);
            r.slot_out = s;
          end
        end
        if (!found) begin
          r.status = STS_FULL;
          r.slot_out = '0;
        end
      end
      OP_UNREGISTER: begin
        if (!slot_used[idx]) begin
          r.status = STS_NOT_FOUND;
        end else begin
          slot_used[idx] = 1'b0;
          slot_mode[idx] = '0;
          slot_prio[idx] = '0;
          used_cnt--;
        end
      end
      default: begin
        if (slot_used[idx]) begin
          r.is_valid = 1'b1;
          r.is_reliable_out = (slot_mode[idx] == MODE_RELIABLE) ||
                              (slot_mode[idx] == MODE_ORDERED);
          r.is_ordered_out = (slot_mode[idx] == MODE_ORDERED);
          r.priority_out = slot_prio[idx];
        end
      end
    endcase
    r.used_count = CNT_W'(used_cnt);
    return r;
  endfunction

  // next slot at or above start that is live (or was ever written)
  function automatic logic [IDX_W-1:0] seek_slot(logic [IDX_W-1:0] start, bit by_history);
    logic [IDX_W-1:0] s;
    int               k;
    for (k = 0; k < SLOTS_DEF; k++) begin
      s = start + IDX_W'(k);
      if (by_history ? ever_used[s] : slot_used[s]) return s;
    end
    return start;
  endfunction

  // offer one word, wait for acceptance, queue its expected result
  task automatic send_word(cst_op_t op, logic [IDX_W-1:0] idx, logic [1:0] mode,
                           logic [7:0] prio, bit use_typed, cst_out_t typed_out);
    cst_in_t  w;
    cst_out_t pred;
    if (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    w = '0;
    w.slot_index = idx;
    w.mode_in = mode;
    w.priority_in = prio;
    in_tdata <= w;
    in_tuser <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = apply_slot_op(op, idx, mode, prio);
    results_due.push_back(use_typed ? typed_out : pred);
    n_sent++;
  endtask

  // one random word; unreg_pct steers toward freeing slots
  task automatic send_random(int unsigned unreg_pct);
    cst_op_t          op;
    logic [IDX_W-1:0] idx;
    if ($urandom_range(99) < unreg_pct) begin
      op = OP_UNREGISTER;
    end else begin
      case ($urandom_range(2))
        0:       op = OP_REGISTER;
        1:       op = OP_OPEN;
        default: op = OP_QUERY;
      endcase
    end
    case ($urandom_range(3))
      0:       idx = IDX_W'($urandom_range(15));
      1:       idx = $urandom_range(1) ? 8'hFF : 8'h00;
      default: idx = IDX_W'($urandom_range(255));
    endcase
    if (op == OP_UNREGISTER && $urandom_range(1)) idx = seek_slot(idx, 1'b0);
    // never look at an entry that was never written
    if (op == OP_QUERY) begin
      if (!ever_used[idx]) idx = seek_slot(idx, 1'b1);
      if (!ever_used[idx]) op = OP_OPEN;
    end
    send_word(op, idx, 2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // let every queued result drain before going on
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // receiver: random stalls, one long hold-off
  always begin : rx_drive
    @(posedge clk);
    if (n_sent >= 150 && !hold_done) begin
      out_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_done = 1'b1;
    end else begin
      out_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    cst_out_t got;
    cst_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = cst_out_t'(out_tdata);
      if (results_due.size() == 0) begin
        $display("%0t: result word %h with nothing expected", $time, out_tdata);
        err_cnt++;
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          err_cnt++;
        end
        if (got.slot_out !== want.slot_out) begin
          $display("%0t: slot_out expected %0d actual %0d", $time, want.slot_out,
                   got.slot_out);
          err_cnt++;
        end
        if (got.is_valid !== want.is_valid) begin
          $display("%0t: is_valid expected %0d actual %0d", $time, want.is_valid,
                   got.is_valid);
          err_cnt++;
        end
        if (got.is_reliable_out !== want.is_reliable_out) begin
          $display("%0t: is_reliable_out expected %0d actual %0d", $time,
                   want.is_reliable_out, got.is_reliable_out);
          err_cnt++;
        end
        if (got.is_ordered_out !== want.is_ordered_out) begin
          $display("%0t: is_ordered_out expected %0d actual %0d", $time,
                   want.is_ordered_out, got.is_ordered_out);
          err_cnt++;
        end
        if (got.priority_out !== want.priority_out) begin
          $display("%0t: priority_out expected %0d actual %0d", $time,
                   want.priority_out, got.priority_out);
          err_cnt++;
        end
        if (got.used_count !== want.used_count) begin
          $display("%0t: used_count expected %0d actual %0d", $time, want.used_count,
                   got.used_count);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin : stall_watch
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    cst_out_t typed_out;
    int       i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (i = 0; i < $size(dir_tab); i++) begin
      typed_out = '0;
      typed_out.status = dir_tab[i].st;
      typed_out.slot_out = dir_tab[i].slot;
      typed_out.is_valid = dir_tab[i].v;
      typed_out.is_reliable_out = dir_tab[i].r;
      typed_out.is_ordered_out = dir_tab[i].o;
      typed_out.priority_out = dir_tab[i].p;
      typed_out.used_count = dir_tab[i].cnt;
      send_word(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].mode, dir_tab[i].prio,
                dir_tab[i].typed, typed_out);
    end

    // mixed traffic; the receiver hold-off lands in here
    repeat (350) send_random(25);

    // fill the whole table, mostly through the free search
    while (used_cnt < SLOTS_DEF) begin
      if ($urandom_range(99) < 80)
        send_word(OP_OPEN, 8'($urandom_range(255)), 2'($urandom_range(3)),
                  8'($urandom_range(255)), 1'b0, '0);
      else
        send_word(OP_REGISTER, 8'($urandom_range(255)), 2'($urandom_range(3)),
                  8'($urandom_range(255)), 1'b0, '0);
    end

    // full table: open reports full, register reports in use, query reads live entries
    send_word(OP_OPEN, 8'h00, 2'd1, 8'h11, 1'b0, '0);
    send_word(OP_OPEN, 8'hFF, 2'd2, 8'h22, 1'b0, '0);
    repeat (4) send_word(OP_OPEN, 8'($urandom_range(255)), 2'd0, 8'h33, 1'b0, '0);
    repeat (3) send_word(OP_REGISTER, 8'($urandom_range(255)), 2'd1, 8'h44, 1'b0, '0);
    repeat (3) send_word(OP_QUERY, 8'($urandom_range(255)), 2'd0, 8'h00, 1'b0, '0);
    // free one slot and let the search find the single hole
    send_word(OP_UNREGISTER, 8'd77, 2'd0, 8'h00, 1'b0, '0);
    send_word(OP_OPEN, 8'd78, 2'd2, 8'h66, 1'b0, '0);
    send_word(OP_OPEN, 8'd78, 2'd2, 8'h66, 1'b0, '0);

    // sender pause until everything has come back
    drain_results();

    // mostly freeing slots
    repeat (250) send_random(70);

    // mixed traffic to the end
    while (n_sent < TOTAL_WORDS) send_random(25);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
